### rtl/entity_allocator_with_type_masks_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef ENTITY_ALLOCATOR_WITH_TYPE_MASKS_DEFINES_SVH
`define ENTITY_ALLOCATOR_WITH_TYPE_MASKS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ent_alloc_pkg.sv
package ent_alloc_pkg;

    // Default sizing
    localparam int MAX_ENTITIES_DEF = 256;
    localparam int MASK_BITS_DEF    = 64;

    // Fixed field widths
    localparam int MODE_W     = 3;
    localparam int ENT_W      = 8;
    localparam int CTYPE_W    = 6;
    localparam int STATUS_W   = 3;
    localparam int MASK_W     = 64;
    localparam int LIVE_W     = 9;
    localparam int NTYPES_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLONE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TYPE     = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_TYPES       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPES_WITH_DATA = 2'd1;

    localparam logic [NTYPES_W-1:0] NUM_TYPES_RST = 7'd64;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_en;
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
    } dp_status_t;

endpackage

### rtl/ent_alloc_if.sv
// Command channel
interface ent_alloc_cmd_if;
    import ent_alloc_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ENT_W-1:0]    entity;
    logic [CTYPE_W-1:0]  component_type;

    modport source (output valid, output mode, output entity, output component_type,
                    input ready);
    modport sink   (input valid, input mode, input entity, input component_type,
                    output ready);
endinterface

// Result channel
interface ent_alloc_res_if;
    import ent_alloc_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ENT_W-1:0]    entity_out;
    logic [MASK_W-1:0]   entity_mask;
    logic [LIVE_W-1:0]   live_count;

    modport source (output valid, output status, output entity_out, output entity_mask,
                    output live_count, input ready);
    modport sink   (input valid, input status, input entity_out, input entity_mask,
                    input live_count, output ready);
endinterface

// Configuration write channel
interface ent_alloc_cfg_if;
    import ent_alloc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ent_alloc_ctrl.sv
module ent_alloc_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  ent_alloc_pkg::dp_status_t sts,
    output ent_alloc_pkg::ctrl_cmd_t  cmd
);
    import ent_alloc_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // Output slot is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Sequencer
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/ent_alloc_dp.sv
module ent_alloc_dp #(
    parameter int MAX_ENTITIES = ent_alloc_pkg::MAX_ENTITIES_DEF,
    parameter int MASK_BITS    = ent_alloc_pkg::MASK_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ent_alloc_pkg::ctrl_cmd_t               cmd,
    output ent_alloc_pkg::dp_status_t              sts,
    input  logic [ent_alloc_pkg::MODE_W-1:0]       mode,
    input  logic [ent_alloc_pkg::ENT_W-1:0]        entity,
    input  logic [ent_alloc_pkg::CTYPE_W-1:0]      component_type,
    input  logic                                   cfg_valid,
    input  logic [ent_alloc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ent_alloc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [ent_alloc_pkg::STATUS_W-1:0]     status,
    output logic [ent_alloc_pkg::ENT_W-1:0]        entity_out,
    output logic [ent_alloc_pkg::MASK_W-1:0]       entity_mask,
    output logic [ent_alloc_pkg::LIVE_W-1:0]       live_count
);
    import ent_alloc_pkg::*;

    localparam int ID_W  = $clog2(MAX_ENTITIES);
    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
    localparam int EXT_W = (ID_W > ENT_W) ? ID_W : ENT_W;

    localparam logic [CNT_W-1:0]     MAX_CNT     = CNT_W'(MAX_ENTITIES);
    localparam logic [EXT_W:0]       MAX_EXT     = (EXT_W + 1)'(MAX_ENTITIES);
    localparam logic [ID_W-1:0]      LAST_ID     = ID_W'(MAX_ENTITIES - 1);
    localparam logic [MASK_BITS-1:0] ACTIVE_MASK = MASK_BITS'(1);

    // Memories
    logic [ID_W-1:0]      stack_mem [MAX_ENTITIES];
    logic [MASK_BITS-1:0] mask_mem  [MAX_ENTITIES];
    logic [ID_W-1:0]      stack_rd_reg;
    logic [MASK_BITS-1:0] mask_rd_reg;

    // Config and allocator state
    logic [NTYPES_W-1:0]   num_types_reg;
    logic [CFG_DATA_W-1:0] twd_reg;
    logic [CNT_W-1:0]      free_top_reg, free_top_next;
    logic [CNT_W-1:0]      active_reg, active_next;
    logic [ID_W-1:0]       clr_cnt_reg;

    // Latched command
    logic [MODE_W-1:0]  mode_reg;
    logic [EXT_W-1:0]   ent_reg;
    logic [CTYPE_W-1:0] ctype_reg;

    // Output payload
    logic [STATUS_W-1:0] status_reg;
    logic [ENT_W-1:0]    ent_out_reg;
    logic [MASK_W-1:0]   mask_out_reg;
    logic [LIVE_W-1:0]   live_reg;

    // Write ports
    logic                 stack_we;
    logic [ID_W-1:0]      stack_waddr;
    logic [ID_W-1:0]      stack_wdata;
    logic                 mask_we;
    logic [ID_W-1:0]      mask_waddr;
    logic [MASK_BITS-1:0] mask_wdata;

    // Decode
    logic [EXT_W-1:0]     ent_in_ext;
    logic [ID_W-1:0]      ent_in_idx;
    logic [CNT_W-1:0]     free_top_dec;
    logic [ID_W-1:0]      pop_addr;
    logic [ID_W-1:0]      ent_idx;
    logic                 in_range;
    logic                 active;
    logic                 can_pop;
    logic                 can_push;
    logic                 type_ok;
    logic [MASK_BITS-1:0] type_bit;
    logic [MASK_BITS-1:0] upd_mask;
    logic [STATUS_W-1:0]  res_status;
    logic [EXT_W-1:0]     res_id;
    logic [MASK_BITS-1:0] res_mask;
    logic                 op_we_stack;
    logic                 op_we_mask;
    logic [ID_W-1:0]      op_mask_addr;
    logic [MASK_BITS-1:0] op_mask_data;

    assign ent_in_ext   = EXT_W'(entity);
    assign ent_in_idx   = ent_in_ext[ID_W-1:0];
    assign free_top_dec = free_top_reg - CNT_W'(1);
    assign pop_addr     = free_top_dec[ID_W-1:0];

    assign ent_idx  = ent_reg[ID_W-1:0];
    assign in_range = {1'b0, ent_reg} < MAX_EXT;
    assign active   = in_range && mask_rd_reg[0];
    assign can_pop  = free_top_reg != '0;
    assign can_push = free_top_reg < MAX_CNT;

    // Type must be in use, fit the mask and carry data
    assign type_ok  = (ctype_reg != '0) && ({1'b0, ctype_reg} < num_types_reg)
                      && (ctype_reg < MASK_BITS) && twd_reg[ctype_reg];
    assign type_bit = ACTIVE_MASK << ctype_reg;
    assign upd_mask = (mode_reg == MODE_ADD) ? (mask_rd_reg | type_bit)
                                             : (mask_rd_reg & ~type_bit);

    assign sts.clr_last = clr_cnt_reg == LAST_ID;

    // Operation evaluation on read data
    always_comb
    begin
        res_status    = ST_OK;
        res_id        = ent_reg;
        res_mask      = in_range ? mask_rd_reg : '0;
        op_we_stack   = 1'b0;
        op_we_mask    = 1'b0;
        op_mask_addr  = ent_idx;
        op_mask_data  = '0;
        free_top_next = free_top_reg;
        active_next   = active_reg;
        case (mode_reg)
            MODE_CREATE:
            begin
                if (can_pop)
                begin
                    op_we_mask    = 1'b1;
                    op_mask_addr  = stack_rd_reg;
                    op_mask_data  = ACTIVE_MASK;
                    res_id        = EXT_W'(stack_rd_reg);
                    res_mask      = ACTIVE_MASK;
                    free_top_next = free_top_dec;
                    active_next   = active_reg + CNT_W'(1);
                end
                else
                begin
                    res_status = ST_NOFREE;
                end
            end
            MODE_DELETE:
            begin
                if (!in_range)
                begin
                    res_status = ST_RANGE;
                end
                else if (!active)
                begin
                    res_status = ST_INACTIVE;
                end
                else
                begin
                    op_we_mask = 1'b1;
                    res_mask   = '0;
                    if (active_reg != '0)
                    begin
                        active_next = active_reg - CNT_W'(1);
                    end
                    if (can_push)
                    begin
                        op_we_stack   = 1'b1;
                        free_top_next = free_top_reg + CNT_W'(1);
                    end
                end
            end
            MODE_CLONE:
            begin
                if (!in_range)
                begin
                    res_status = ST_RANGE;
                end
                else if (!active)
                begin
                    res_status = ST_INACTIVE;
                end
                else if (!can_pop)
                begin
                    res_status = ST_NOFREE;
                end
                else
                begin
                    op_we_mask    = 1'b1;
                    op_mask_addr  = stack_rd_reg;
                    op_mask_data  = mask_rd_reg;
                    res_id        = EXT_W'(stack_rd_reg);
                    res_mask      = mask_rd_reg;
                    free_top_next = free_top_dec;
                    active_next   = active_reg + CNT_W'(1);
                end
            end
            MODE_ADD, MODE_REMOVE:
            begin
                if (!in_range)
                begin
                    res_status = ST_RANGE;
                end
                else if (!active)
                begin
                    res_status = ST_INACTIVE;
                end
                else if (!type_ok)
                begin
                    res_status = ST_TYPE;
                end
                else
                begin
                    op_we_mask   = 1'b1;
                    op_mask_data = upd_mask;
                    res_mask     = upd_mask;
                end
            end
            default:
            begin
                res_status = ST_TYPE;
            end
        endcase
    end

    // Write port muxing: clearing pass or operation commit
    always_comb
    begin
        if (cmd.clr_en)
        begin
            stack_we    = 1'b1;
            stack_waddr = clr_cnt_reg;
            stack_wdata = LAST_ID - clr_cnt_reg;
            mask_we     = 1'b1;
            mask_waddr  = clr_cnt_reg;
            mask_wdata  = '0;
        end
        else
        begin
            stack_we    = cmd.commit && op_we_stack;
            stack_waddr = free_top_reg[ID_W-1:0];
            stack_wdata = ent_idx;
            mask_we     = cmd.commit && op_we_mask;
            mask_waddr  = op_mask_addr;
            mask_wdata  = op_mask_data;
        end
    end

    // Free-id stack memory
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (cmd.accept)
        begin
            stack_rd_reg <= stack_mem[pop_addr];
        end
    end

    // Type mask memory
    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        if (cmd.accept)
        begin
            mask_rd_reg <= mask_mem[ent_in_idx];
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_types_reg <= NUM_TYPES_RST;
            twd_reg       <= '0;
            free_top_reg  <= MAX_CNT;
            active_reg    <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_NUM_TYPES:       num_types_reg <= cfg_data[NTYPES_W-1:0];
                    REG_TYPES_WITH_DATA: twd_reg       <= cfg_data;
                    default:             ;
                endcase
            end
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + ID_W'(1);
            end
            if (cmd.commit)
            begin
                free_top_reg <= free_top_next;
                active_reg   <= active_next;
            end
        end
    end

    // Command latch and result register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg  <= mode;
            ent_reg   <= ent_in_ext;
            ctype_reg <= component_type;
        end
        if (cmd.commit)
        begin
            status_reg   <= res_status;
            ent_out_reg  <= res_id[ENT_W-1:0];
            mask_out_reg <= MASK_W'(res_mask);
            live_reg     <= LIVE_W'(active_next);
        end
    end

    assign status      = status_reg;
    assign entity_out  = ent_out_reg;
    assign entity_mask = mask_out_reg;
    assign live_count  = live_reg;

endmodule

### rtl/entity_allocator_with_type_masks.sv
// Channel   Modport  Direction  Payload
// cmd       sink     in         mode, entity, component_type
// res       source   out        status, entity_out, entity_mask, live_count
// cfg       sink     in         index, data (always ready)
//
// Each transaction reads the free stack and mask memories, then evaluates and
// writes back the mask (and the stack on delete) and the result register.
// After reset a clearing pass over every id loads the free stack and zeroes
// the masks; cmd.ready stays low during it.
// A new command is taken while a result waits; its write-back holds until
// the waiting result is taken.
`include "entity_allocator_with_type_masks_defines.svh"

module entity_allocator_with_type_masks #(
    parameter int MAX_ENTITIES = ent_alloc_pkg::MAX_ENTITIES_DEF,
    parameter int MASK_BITS    = ent_alloc_pkg::MASK_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    ent_alloc_cmd_if.sink    cmd,
    ent_alloc_res_if.source  res,
    ent_alloc_cfg_if.sink    cfg
);
    import ent_alloc_pkg::*;

    ctrl_cmd_t  ctl_cmd;
    dp_status_t dp_sts;

    // User must write registers only while idle; not enforced by the block.
    assign cfg.ready = 1'b1;

    ent_alloc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .sts       (dp_sts),
        .cmd       (ctl_cmd)
    );

    ent_alloc_dp #(
        .MAX_ENTITIES (MAX_ENTITIES),
        .MASK_BITS    (MASK_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .sts            (dp_sts),
        .mode           (cmd.mode),
        .entity         (cmd.entity),
        .component_type (cmd.component_type),
        .cfg_valid      (cfg.valid && cfg.ready),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .status         (res.status),
        .entity_out     (res.entity_out),
        .entity_mask    (res.entity_mask),
        .live_count     (res.live_count)
    );

    // Checks
    `EA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, cmd.valid && cmd.ready, !cmd.ready, "command taken while busy")
    `EA_ASSERT_SAME(a_commit_slot_free, clk, rst_n, ctl_cmd.commit, !res.valid || res.ready, "result overwritten")
    `EA_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, ctl_cmd.commit, res.valid, "commit without result")
    `EA_ASSERT_SAME(a_no_accept_in_clear, clk, rst_n, ctl_cmd.clr_en, !cmd.ready, "ready during clear")

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ent_alloc_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_ITEMS = 240;
    localparam int NUM_PHASES  = 6;

    // Modes with no operation behind them
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENT_W-1:0]    ent_id;
        logic [MASK_W-1:0]   mask;
        logic [LIVE_W-1:0]   live;
    } alloc_result_t;

    typedef enum logic [1:0] {ROW_OP, ROW_OP_TYPED, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [MODE_W-1:0]     op;
        logic [ENT_W-1:0]      ent;
        logic [CTYPE_W-1:0]    ct;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        alloc_result_t         want;
    } stim_row_t;

    typedef enum logic [1:0] {PROF_FILL, PROF_MIX, PROF_DRAIN} profile_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ent_alloc_cmd_if cmd_if ();
    ent_alloc_res_if res_if ();
    ent_alloc_cfg_if cfg_if ();

    entity_allocator_with_type_masks dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow allocator state
    logic [ENT_W-1:0]      free_ids [MAX_ENTITIES_DEF];
    logic [MASK_W-1:0]     mask_mem [MAX_ENTITIES_DEF];
    int                    free_cnt;
    int                    live_total;
    logic [NTYPES_W-1:0]   n_types;
    logic [CFG_DATA_W-1:0] data_types;

    alloc_result_t expected_results [$];
    stim_row_t     dir_rows [$];
    int            errors = 0;
    int            cycle_count = 0;
    bit            calm;

    // Type must be nonzero, below the type count and carry data
    function automatic bit type_valid(logic [CTYPE_W-1:0] ct);
        return (ct != 0) && ({1'b0, ct} < n_types) && data_types[ct];
    endfunction

    // Apply one operation to the shadow state and return its result
    function automatic alloc_result_t apply_alloc_op(logic [MODE_W-1:0] op,
                                                     logic [ENT_W-1:0] ent,
                                                     logic [CTYPE_W-1:0] ct);
        alloc_result_t r;
        logic [ENT_W-1:0] nid;
        logic active;
        active = mask_mem[ent][0];
        r.status = ST_OK;
        r.ent_id = ent;
        // An 8-bit id is always in range here
        case (op)
            MODE_CREATE:
            begin
                if (free_cnt == 0)
                    r.status = ST_NOFREE;
                else
                begin
                    free_cnt--;
                    nid = free_ids[free_cnt];
                    mask_mem[nid] = 64'd1;
                    live_total++;
                    r.ent_id = nid;
                end
            end
            MODE_DELETE:
            begin
                if (!active)
                    r.status = ST_INACTIVE;
                else
                begin
                    if (live_total != 0)
                        live_total--;
                    mask_mem[ent] = '0;
                    if (free_cnt < MAX_ENTITIES_DEF)
                    begin
                        free_ids[free_cnt] = ent;
                        free_cnt++;
                    end
                end
            end
            MODE_CLONE:
            begin
                if (!active)
                    r.status = ST_INACTIVE;
                else if (free_cnt == 0)
                    r.status = ST_NOFREE;
                else
                begin
                    free_cnt--;
                    nid = free_ids[free_cnt];
                    mask_mem[nid] = mask_mem[ent];
                    live_total++;
                    r.ent_id = nid;
                end
            end
            MODE_ADD, MODE_REMOVE:
            begin
                if (!active)
                    r.status = ST_INACTIVE;
                else if (!type_valid(ct))
                    r.status = ST_TYPE;
                else if (op == MODE_ADD)
                    mask_mem[ent] = mask_mem[ent] | (64'd1 << ct);
                else
                    mask_mem[ent] = mask_mem[ent] & ~(64'd1 << ct);
            end
            default:
                r.status = ST_TYPE;
        endcase
        r.mask = mask_mem[r.ent_id];
        r.live = live_total[LIVE_W-1:0];
        return r;
    endfunction

    // Random active id, or any id when none is active
    function automatic logic [ENT_W-1:0] pick_live();
        int start;
        int idx;
        start = $urandom_range(0, MAX_ENTITIES_DEF - 1);
        for (int k = 0; k < MAX_ENTITIES_DEF; k++)
        begin
            idx = (start + k) % MAX_ENTITIES_DEF;
            if (mask_mem[idx][0])
                return idx[ENT_W-1:0];
        end
        return start[ENT_W-1:0];
    endfunction

    function automatic stim_row_t op_row(logic [MODE_W-1:0] op, logic [ENT_W-1:0] ent,
                                         logic [CTYPE_W-1:0] ct);
        stim_row_t row;
        row = '{ROW_OP, op, ent, ct, '0, '0, '0};
        return row;
    endfunction

    function automatic stim_row_t checked_row(logic [MODE_W-1:0] op, logic [ENT_W-1:0] ent,
                                              logic [CTYPE_W-1:0] ct,
                                              logic [STATUS_W-1:0] st, logic [ENT_W-1:0] eo,
                                              logic [MASK_W-1:0] m, logic [LIVE_W-1:0] lv);
        stim_row_t row;
        row = '{ROW_OP_TYPED, op, ent, ct, '0, '0, '0};
        row.want = '{st, eo, m, lv};
        return row;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '{ROW_REG, MODE_CREATE, '0, '0, idx, data, '0};
        return row;
    endfunction

    // Issue one command transaction and queue its expected result
    task automatic send_op(input logic [MODE_W-1:0] op, input logic [ENT_W-1:0] ent,
                           input logic [CTYPE_W-1:0] ct, input bit typed,
                           input alloc_result_t want);
        int gap;
        alloc_result_t pred;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.mode           <= op;
        cmd_if.entity         <= ent;
        cmd_if.component_type <= ct;
        do @(posedge clk); while (!cmd_if.ready);
        pred = apply_alloc_op(op, ent, ct);
        expected_results.push_back(typed ? want : pred);
    endtask

    // Register write, only once every result is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cmd_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == REG_NUM_TYPES)
            n_types = val[NTYPES_W-1:0];
        else if (idx == REG_TYPES_WITH_DATA)
            data_types = val;
    endtask

    // Result monitor and receiver stalls
    int hold = 0;
    initial
    begin
        alloc_result_t got;
        alloc_result_t exp_r;
        res_if.ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (res_if.valid && res_if.ready)
                begin
                    got = '{res_if.status, res_if.entity_out, res_if.entity_mask,
                            res_if.live_count};
                    if (expected_results.size() == 0)
                    begin
                        $error("result with nothing expected: status %0d entity %0d",
                               got.status, got.ent_id);
                        errors++;
                    end
                    else
                    begin
                        exp_r = expected_results.pop_front();
                        if (got.status !== exp_r.status)
                        begin
                            $error("status: expected %0d, actual %0d", exp_r.status,
                                   got.status);
                            errors++;
                        end
                        if (got.ent_id !== exp_r.ent_id)
                        begin
                            $error("entity_out: expected %0d, actual %0d", exp_r.ent_id,
                                   got.ent_id);
                            errors++;
                        end
                        if (got.mask !== exp_r.mask)
                        begin
                            $error("entity_mask: expected %h, actual %h", exp_r.mask,
                                   got.mask);
                            errors++;
                        end
                        if (got.live !== exp_r.live)
                        begin
                            $error("live_count: expected %0d, actual %0d", exp_r.live,
                                   got.live);
                            errors++;
                        end
                    end
                    hold = calm ? 0 : $urandom_range(0, 3);
                    if (hold > 0)
                        res_if.ready <= 1'b0;
                end
                else if (hold > 0)
                begin
                    hold--;
                    if (hold == 0)
                        res_if.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [MODE_W-1:0]  op;
        logic [ENT_W-1:0]   ent;
        logic [CTYPE_W-1:0] ct;
        int r;
        int w_cr, w_cl, w_de, w_ad, w_rm;
        profile_t phase_prof [NUM_PHASES];
        int       phase_ntypes [NUM_PHASES];

        // Known values on every input from time zero
        cmd_if.valid          = 1'b0;
        cmd_if.mode           = MODE_CREATE;
        cmd_if.entity         = '0;
        cmd_if.component_type = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = REG_NUM_TYPES;
        cfg_if.data           = '0;

        phase_prof   = '{PROF_FILL, PROF_FILL, PROF_MIX, PROF_DRAIN, PROF_FILL, PROF_DRAIN};
        phase_ntypes = '{64, 64, 1, 33, 63, 2};
        calm         = 1'b0;

        // Shadow state after reset: id 0 on top of the free stack
        for (int i = 0; i < MAX_ENTITIES_DEF; i++)
        begin
            free_ids[i] = 8'(MAX_ENTITIES_DEF - 1 - i);
            mask_mem[i] = '0;
        end
        free_cnt   = MAX_ENTITIES_DEF;
        live_total = 0;
        n_types    = NUM_TYPES_RST;
        data_types = '0;

        // Directed rows: reset defaults first, then the type checks
        dir_rows.push_back(checked_row(MODE_CREATE, 8'd0, 6'd0, ST_OK, 8'd0, 64'd1, 9'd1));
        dir_rows.push_back(checked_row(MODE_CREATE, 8'd255, 6'd63, ST_OK, 8'd1, 64'd1, 9'd2));
        dir_rows.push_back(checked_row(MODE_DELETE, 8'd255, 6'd0, ST_INACTIVE, 8'd255, 64'd0,
                                       9'd2));
        dir_rows.push_back(checked_row(MODE_ADD, 8'd0, 6'd5, ST_TYPE, 8'd0, 64'd1, 9'd2));
        dir_rows.push_back(checked_row(MODE_REMOVE, 8'd0, 6'd0, ST_TYPE, 8'd0, 64'd1, 9'd2));
        dir_rows.push_back(checked_row(MODE_CLONE, 8'd0, 6'd0, ST_OK, 8'd2, 64'd1, 9'd3));
        dir_rows.push_back(checked_row(MODE_CLONE, 8'd200, 6'd0, ST_INACTIVE, 8'd200, 64'd0,
                                       9'd3));
        dir_rows.push_back(checked_row(MODE_SPARE_LO, 8'd1, 6'd0, ST_TYPE, 8'd1, 64'd1, 9'd3));
        dir_rows.push_back(checked_row(MODE_SPARE_HI, 8'd255, 6'd63, ST_TYPE, 8'd255, 64'd0,
                                       9'd3));
        dir_rows.push_back(op_row(3'(MODE_SPARE_LO + 1), 8'd0, 6'd0));
        dir_rows.push_back(checked_row(MODE_DELETE, 8'd1, 6'd0, ST_OK, 8'd1, 64'd0, 9'd2));
        // freed id comes back first
        dir_rows.push_back(checked_row(MODE_CREATE, 8'd128, 6'd0, ST_OK, 8'd1, 64'd1, 9'd3));
        dir_rows.push_back(checked_row(MODE_ADD, 8'd2, 6'd63, ST_TYPE, 8'd2, 64'd1, 9'd3));
        dir_rows.push_back(checked_row(MODE_DELETE, 8'd0, 6'd0, ST_OK, 8'd0, 64'd0, 9'd2));
        dir_rows.push_back(checked_row(MODE_DELETE, 8'd0, 6'd0, ST_INACTIVE, 8'd0, 64'd0, 9'd2));
        dir_rows.push_back(checked_row(MODE_ADD, 8'd0, 6'd63, ST_INACTIVE, 8'd0, 64'd0, 9'd2));
        dir_rows.push_back(reg_row(REG_NUM_TYPES, 64'd64));
        dir_rows.push_back(reg_row(REG_TYPES_WITH_DATA, '1));
        dir_rows.push_back(checked_row(MODE_ADD, 8'd2, 6'd63, ST_OK, 8'd2,
                                       64'h8000_0000_0000_0001, 9'd2));
        dir_rows.push_back(checked_row(MODE_ADD, 8'd2, 6'd0, ST_TYPE, 8'd2,
                                       64'h8000_0000_0000_0001, 9'd2));
        dir_rows.push_back(checked_row(MODE_ADD, 8'd2, 6'd1, ST_OK, 8'd2,
                                       64'h8000_0000_0000_0003, 9'd2));
        dir_rows.push_back(checked_row(MODE_REMOVE, 8'd2, 6'd63, ST_OK, 8'd2, 64'd3, 9'd2));
        dir_rows.push_back(op_row(MODE_CLONE, 8'd2, 6'd0));
        dir_rows.push_back(reg_row(REG_NUM_TYPES, 64'd1));
        dir_rows.push_back(op_row(MODE_ADD, 8'd2, 6'd1));
        dir_rows.push_back(op_row(MODE_REMOVE, 8'd2, 6'd0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                send_op(dir_rows[i].op, dir_rows[i].ent, dir_rows[i].ct,
                        dir_rows[i].kind == ROW_OP_TYPED, dir_rows[i].want);
        end

        // Random phases: fill to exhaustion, mix, drain, refill, drain
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_NUM_TYPES, 64'(phase_ntypes[p]));
            write_reg(REG_TYPES_WITH_DATA,
                      (p == 0 || p == NUM_PHASES - 1) ? '1 : {$urandom, $urandom});
            calm = (p == 2);
            case (phase_prof[p])
                PROF_FILL:  begin w_cr = 55; w_cl = 20; w_de = 5;  w_ad = 10; w_rm = 5;  end
                PROF_MIX:   begin w_cr = 20; w_cl = 10; w_de = 25; w_ad = 22; w_rm = 18; end
                default:    begin w_cr = 5;  w_cl = 5;  w_de = 65; w_ad = 10; w_rm = 10; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < w_cr)
                    op = MODE_CREATE;
                else if (r < w_cr + w_cl)
                    op = MODE_CLONE;
                else if (r < w_cr + w_cl + w_de)
                    op = MODE_DELETE;
                else if (r < w_cr + w_cl + w_de + w_ad)
                    op = MODE_ADD;
                else if (r < w_cr + w_cl + w_de + w_ad + w_rm)
                    op = MODE_REMOVE;
                else
                    op = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
                // mostly live ids, some random ones for the inactive path
                if (op != MODE_CREATE && live_total > 0 && $urandom_range(0, 9) < 8)
                    ent = pick_live();
                else
                    ent = 8'($urandom_range(0, MAX_ENTITIES_DEF - 1));
                if ($urandom_range(0, 3) != 0)
                    ct = 6'($urandom_range(0, (n_types > 64) ? 63 : n_types - 1));
                else
                    ct = 6'($urandom_range(0, 63));
                send_op(op, ent, ct, 1'b0, '0);
            end
        end
        cmd_if.valid <= 1'b0;
        calm = 1'b0;

        // Drain outstanding results
        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
